[src/ttcw_pkg.sv]
package ttcw_pkg;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CHAR_W    = 8;
    localparam int ROW_W     = 7;
    localparam int COL_W     = 8;

    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CHAR_W-1:0]    t_char;

    localparam t_cfg_idx REG_WIN_WIDTH  = 1'b0;
    localparam t_cfg_idx REG_WIN_HEIGHT = 1'b1;

    localparam t_cfg WIN_WIDTH_RST  = 12'd640;
    localparam t_cfg WIN_HEIGHT_RST = 12'd480;
    localparam t_cfg WIN_W_MARGIN   = 12'd16;
    localparam t_cfg WIN_H_MARGIN   = 12'd36;

    localparam int MIN_COLS = 40;
    localparam int MIN_ROWS = 10;

    localparam t_char CH_NEWLINE   = 8'd10;
    localparam t_char CH_RETURN    = 8'd13;
    localparam t_char CH_BACKSPACE = 8'd8;
    localparam t_char CH_BLANK     = 8'h20;

    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

endpackage

[src/ttcw_req_if.sv]
interface ttcw_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [ttcw_pkg::CHAR_W-1:0]   char_code;
    logic [ttcw_pkg::ROW_W-1:0]    read_row;
    logic [ttcw_pkg::COL_W-1:0]    read_col;

    modport source (output valid, mode, char_code, read_row, read_col, input ready);
    modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

[src/ttcw_rsp_if.sv]
interface ttcw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ttcw_pkg::CHAR_W-1:0]   cell_char;
    logic [ttcw_pkg::COL_W-1:0]    cursor_col;
    logic [ttcw_pkg::ROW_W-1:0]    cursor_row;
    logic                          did_scroll;

    modport source (output valid, cell_char, cursor_col, cursor_row, did_scroll, input ready);
    modport sink   (input valid, cell_char, cursor_col, cursor_row, did_scroll, output ready);
endinterface

[src/ttcw_ram.sv]
module ttcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/text_terminal_char_writer_unit.sv]
// Text console character store with a cursor.
// Input channel i_req carries one word per request: mode 0 puts char_code at
// the cursor (newline, return and backspace act as control codes), mode 1
// reads the cell at read_row/read_col. Output channel o_rsp returns one word
// per request: the cell read (0 in put mode or out of range), the cursor
// after the request and a flag for a scroll.
// The window size registers are written through i_cfg_we/i_cfg_addr/
// i_cfg_data (index 0 width, 1 height) and set the visible grid.
// The result is registered and shows on o_rsp.valid in the cycle after
// acceptance. A put or read that causes no scroll lets a word enter every
// cycle while results are taken. A scroll copies the visible rows up one
// cell per cycle through the single read and write port of the store,
// then blanks the last row and, when a wrapped byte is waiting, stores it
// after the copy; i_req.ready stays low throughout.
// After reset the store is cleared to spaces, one cell per cycle; config
// writes are taken during the clear.
// A result waits in the output register while o_rsp.ready is low; a new
// word is accepted in the same cycle the waiting result is taken.
module text_terminal_char_writer_unit #(
    parameter int MAX_COLS = 200,
    parameter int MAX_ROWS = 100
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  ttcw_pkg::t_cfg_idx      i_cfg_addr,
    input  ttcw_pkg::t_cfg          i_cfg_data,
    ttcw_req_if.sink                i_req,
    ttcw_rsp_if.source              o_rsp
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int LW    = $clog2(MAX_ROWS + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_BLANK = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;

    logic [2:0]            r_state;
    ttcw_pkg::t_cfg        r_win_w;
    ttcw_pkg::t_cfg        r_win_h;
    logic [CW-1:0]         r_cur_col;
    logic [LW-1:0]         r_cur_line;
    logic [AW-1:0]         r_clr_addr;
    logic [CW-1:0]         r_scr_cols;
    logic [LW-1:0]         r_scr_rows;
    logic [CW-1:0]         r_scr_col;
    logic [LW-1:0]         r_scr_row;
    logic [AW-1:0]         r_base;
    logic                  r_post_pend;
    ttcw_pkg::t_char       r_post_char;
    logic                  r_wr_pend;
    logic [AW-1:0]         r_wr_addr;
    logic                  r_out_valid;
    logic [ttcw_pkg::COL_W-1:0] r_out_col;
    logic [ttcw_pkg::ROW_W-1:0] r_out_row;
    logic                  r_out_scr;
    logic                  r_use_ram;

    ttcw_pkg::t_cfg        w_cols_raw;
    ttcw_pkg::t_cfg        w_rows_raw;
    logic [CW-1:0]         w_vis_cols;
    logic [LW-1:0]         w_vis_rows;
    logic                  w_acc;
    logic                  w_put;
    logic                  w_rd;
    logic                  w_rd_ok;
    logic [AW-1:0]         w_rd_addr;
    logic [LW-1:0]         w_line_p1;
    logic                  w_wrap_scroll;
    logic [LW-1:0]         w_nl_line;
    logic [CW-1:0]         n_cur_col;
    logic [LW-1:0]         n_cur_line;
    logic                  w_do_scroll;
    logic                  w_post;
    logic                  w_put_we;
    logic [LW-1:0]         w_put_line;
    logic [CW-1:0]         w_put_col;
    ttcw_pkg::t_char       w_put_data;
    logic [AW-1:0]         w_put_addr;
    logic [AW-1:0]         w_src_addr;
    logic                  w_scroll_go;

    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    ttcw_pkg::t_char       w_ram_wdata;
    logic                  w_ram_re;
    logic [AW-1:0]         w_ram_raddr;
    ttcw_pkg::t_char       w_ram_rdata;

    ttcw_ram #(
        .WIDTH (ttcw_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_cols_raw = (r_win_w >= ttcw_pkg::WIN_W_MARGIN) ?
                        ((r_win_w - ttcw_pkg::WIN_W_MARGIN) >> 3) : '0;
    assign w_rows_raw = (r_win_h >= ttcw_pkg::WIN_H_MARGIN) ?
                        ((r_win_h - ttcw_pkg::WIN_H_MARGIN) >> 3) : '0;

    always_comb begin
        if (w_cols_raw < ttcw_pkg::CFG_W'(ttcw_pkg::MIN_COLS)) begin
            w_vis_cols = CW'(ttcw_pkg::MIN_COLS);
        end else if (w_cols_raw > ttcw_pkg::CFG_W'(MAX_COLS)) begin
            w_vis_cols = CW'(MAX_COLS);
        end else begin
            w_vis_cols = CW'(w_cols_raw);
        end
        if (w_rows_raw < ttcw_pkg::CFG_W'(ttcw_pkg::MIN_ROWS)) begin
            w_vis_rows = LW'(ttcw_pkg::MIN_ROWS);
        end else if (w_rows_raw > ttcw_pkg::CFG_W'(MAX_ROWS)) begin
            w_vis_rows = LW'(MAX_ROWS);
        end else begin
            w_vis_rows = LW'(w_rows_raw);
        end
    end

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_put       = (i_req.mode == ttcw_pkg::MODE_PUT);
    assign w_rd        = (i_req.mode == ttcw_pkg::MODE_READ);

    assign w_rd_ok   = (int'(i_req.read_row) < MAX_ROWS) && (int'(i_req.read_col) < MAX_COLS);
    assign w_rd_addr = AW'(i_req.read_row) * AW'(MAX_COLS) + AW'(i_req.read_col);

    assign w_line_p1     = r_cur_line + LW'(1);
    assign w_wrap_scroll = (w_line_p1 >= w_vis_rows);
    assign w_nl_line     = w_wrap_scroll ? (w_vis_rows - LW'(1)) : w_line_p1;

    always_comb begin
        n_cur_col   = r_cur_col;
        n_cur_line  = r_cur_line;
        w_do_scroll = 1'b0;
        w_post      = 1'b0;
        w_put_we    = 1'b0;
        w_put_line  = r_cur_line;
        w_put_col   = r_cur_col;
        w_put_data  = i_req.char_code;
        if (w_put) begin
            case (i_req.char_code)
                ttcw_pkg::CH_NEWLINE: begin
                    n_cur_col   = '0;
                    n_cur_line  = w_nl_line;
                    w_do_scroll = w_wrap_scroll;
                end
                ttcw_pkg::CH_RETURN: begin
                    n_cur_col = '0;
                end
                ttcw_pkg::CH_BACKSPACE: begin
                    if (r_cur_col != '0) begin
                        n_cur_col  = r_cur_col - CW'(1);
                        w_put_we   = 1'b1;
                        w_put_col  = r_cur_col - CW'(1);
                        w_put_data = ttcw_pkg::CH_BLANK;
                    end
                end
                default: begin
                    if (r_cur_col >= w_vis_cols) begin
                        n_cur_line  = w_nl_line;
                        n_cur_col   = CW'(1);
                        w_do_scroll = w_wrap_scroll;
                        w_post      = w_wrap_scroll;
                        w_put_we    = !w_wrap_scroll;
                        w_put_line  = w_nl_line;
                        w_put_col   = '0;
                    end else begin
                        n_cur_col = r_cur_col + CW'(1);
                        w_put_we  = 1'b1;
                    end
                end
            endcase
        end
    end

    assign w_put_addr  = AW'(w_put_line) * AW'(MAX_COLS) + AW'(w_put_col);
    assign w_src_addr  = r_base + AW'(r_scr_col);
    assign w_scroll_go = w_acc && w_put && w_do_scroll;

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_wr_addr;
        w_ram_wdata = w_ram_rdata;
        w_ram_re    = 1'b0;
        w_ram_raddr = w_src_addr;
        unique case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = ttcw_pkg::CH_BLANK;
            end
            S_IDLE: begin
                w_ram_we    = w_acc && w_put_we;
                w_ram_waddr = w_put_addr;
                w_ram_wdata = w_put_data;
                w_ram_re    = w_acc && w_rd && w_rd_ok;
                w_ram_raddr = w_rd_addr;
            end
            S_COPY: begin
                w_ram_we = r_wr_pend;
                w_ram_re = 1'b1;
            end
            S_BLANK: begin
                w_ram_we = 1'b1;
                if (!r_wr_pend) begin
                    w_ram_waddr = w_src_addr;
                    w_ram_wdata = ttcw_pkg::CH_BLANK;
                end
            end
            S_POST: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_base;
                w_ram_wdata = r_post_char;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w <= ttcw_pkg::WIN_WIDTH_RST;
            r_win_h <= ttcw_pkg::WIN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ttcw_pkg::REG_WIN_WIDTH:  r_win_w <= i_cfg_data;
                ttcw_pkg::REG_WIN_HEIGHT: r_win_h <= i_cfg_data;
                default:                  r_win_w <= r_win_w;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cur_col   <= '0;
            r_cur_line  <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_use_ram   <= 1'b0;
        end else begin
            r_wr_pend <= (r_state == S_COPY);
            r_wr_addr <= w_src_addr - AW'(MAX_COLS);

            if (w_acc) begin
                r_out_valid <= 1'b1;
                r_out_col   <= ttcw_pkg::COL_W'(n_cur_col);
                r_out_row   <= ttcw_pkg::ROW_W'(n_cur_line);
                r_out_scr   <= w_put && w_do_scroll;
                r_use_ram   <= w_rd && w_rd_ok;
                if (w_put) begin
                    r_cur_col  <= n_cur_col;
                    r_cur_line <= n_cur_line;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_scroll_go) begin
                        r_scr_cols  <= w_vis_cols;
                        r_scr_rows  <= w_vis_rows;
                        r_base      <= AW'(MAX_COLS);
                        r_scr_col   <= '0;
                        r_scr_row   <= LW'(1);
                        r_post_pend <= w_post;
                        r_post_char <= i_req.char_code;
                        r_state     <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (r_scr_col == r_scr_cols - CW'(1)) begin
                        r_scr_col <= '0;
                        if (r_scr_row == r_scr_rows - LW'(1)) begin
                            r_state <= S_BLANK;
                        end else begin
                            r_base    <= r_base + AW'(MAX_COLS);
                            r_scr_row <= r_scr_row + LW'(1);
                        end
                    end else begin
                        r_scr_col <= r_scr_col + CW'(1);
                    end
                end
                S_BLANK: begin
                    if (!r_wr_pend) begin
                        if (r_scr_col == r_scr_cols - CW'(1)) begin
                            r_state <= r_post_pend ? S_POST : S_IDLE;
                        end else begin
                            r_scr_col <= r_scr_col + CW'(1);
                        end
                    end
                end
                S_POST: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cell_char  = r_use_ram ? w_ram_rdata : '0;
    assign o_rsp.cursor_col = r_out_col;
    assign o_rsp.cursor_row = r_out_row;
    assign o_rsp.did_scroll = r_out_scr;

    a_line_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_line < LW'(MAX_ROWS))
        else $error("cursor line outside the store");

    a_read_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_use_ram && !o_rsp.ready) |=> $stable(w_ram_rdata))
        else $error("read data changed while the result waits");

    a_scroll_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scroll_go |=> (r_state == S_COPY && r_out_valid && r_out_scr))
        else $error("scroll started without a flagged result");

    a_copy_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY || r_state == S_BLANK) |-> (r_scr_col < r_scr_cols))
        else $error("scroll column past the visible width");

endmodule

[test/text_terminal_char_writer_unit_tb.sv]
`timescale 1ns / 100ps

module text_terminal_char_writer_unit_tb;

    localparam int GRID_COLS    = 200;
    localparam int GRID_ROWS    = 100;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 141;
    localparam int HOLD_CYCLES  = 300;
    localparam int SMALL_AREA   = 800;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct packed {
        logic                       mode;
        ttcw_pkg::t_char            char_code;
        logic [ttcw_pkg::ROW_W-1:0] read_row;
        logic [ttcw_pkg::COL_W-1:0] read_col;
    } t_console_req;

    typedef struct packed {
        ttcw_pkg::t_char            cell_char;
        logic [ttcw_pkg::COL_W-1:0] cursor_col;
        logic [ttcw_pkg::ROW_W-1:0] cursor_row;
        logic                       did_scroll;
    } t_console_rsp;

    class t_screen_sb;
        ttcw_pkg::t_char grid [GRID_ROWS][GRID_COLS];
        int              cur_col;
        int              cur_row;
        int              win_w;
        int              win_h;
        t_console_rsp    want_words [$];
        int              errors;
        int              puts;
        int              reads;
        int              scrolls;

        function new();
            foreach (grid[r, c]) grid[r][c] = ttcw_pkg::CH_BLANK;
            cur_col = 0;
            cur_row = 0;
            win_w   = int'(ttcw_pkg::WIN_WIDTH_RST);
            win_h   = int'(ttcw_pkg::WIN_HEIGHT_RST);
            errors  = 0;
            puts    = 0;
            reads   = 0;
            scrolls = 0;
        endfunction

        function void set_reg(ttcw_pkg::t_cfg_idx idx, ttcw_pkg::t_cfg val);
            if (idx == ttcw_pkg::REG_WIN_WIDTH) begin
                win_w = int'(val);
            end else begin
                win_h = int'(val);
            end
        endfunction

        function int cols();
            int c;
            c = (win_w >= int'(ttcw_pkg::WIN_W_MARGIN)) ?
                (win_w - int'(ttcw_pkg::WIN_W_MARGIN)) / 8 : 0;
            if (c < ttcw_pkg::MIN_COLS) c = ttcw_pkg::MIN_COLS;
            if (c > GRID_COLS) c = GRID_COLS;
            return c;
        endfunction

        function int rows();
            int r;
            r = (win_h >= int'(ttcw_pkg::WIN_H_MARGIN)) ?
                (win_h - int'(ttcw_pkg::WIN_H_MARGIN)) / 8 : 0;
            if (r < ttcw_pkg::MIN_ROWS) r = ttcw_pkg::MIN_ROWS;
            if (r > GRID_ROWS) r = GRID_ROWS;
            return r;
        endfunction

        // move to the next line; shift the visible area up at the bottom
        function logic advance_line(int ncols, int nrows);
            cur_col = 0;
            cur_row++;
            if (cur_row < nrows) return 1'b0;
            for (int r = 0; r + 1 < nrows; r++) begin
                for (int c = 0; c < ncols; c++) grid[r][c] = grid[r + 1][c];
            end
            for (int c = 0; c < ncols; c++) grid[nrows - 1][c] = ttcw_pkg::CH_BLANK;
            cur_row = nrows - 1;
            return 1'b1;
        endfunction

        function void note_word(t_console_req w);
            t_console_rsp e;
            int           ncols;
            int           nrows;
            ncols = cols();
            nrows = rows();
            e = '0;
            if (w.mode == ttcw_pkg::MODE_READ) begin
                reads++;
                if (w.read_row < GRID_ROWS && w.read_col < GRID_COLS) begin
                    e.cell_char = grid[w.read_row][w.read_col];
                end
            end else begin
                puts++;
                if (w.char_code == ttcw_pkg::CH_NEWLINE) begin
                    e.did_scroll = advance_line(ncols, nrows);
                end else if (w.char_code == ttcw_pkg::CH_RETURN) begin
                    cur_col = 0;
                end else if (w.char_code == ttcw_pkg::CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        grid[cur_row][cur_col] = ttcw_pkg::CH_BLANK;
                    end
                end else begin
                    if (cur_col >= ncols) e.did_scroll = advance_line(ncols, nrows);
                    grid[cur_row][cur_col] = w.char_code;
                    cur_col++;
                end
            end
            if (e.did_scroll) scrolls++;
            e.cursor_col = ttcw_pkg::COL_W'(cur_col);
            e.cursor_row = ttcw_pkg::ROW_W'(cur_row);
            want_words.push_back(e);
        endfunction

        function void check_word(t_console_rsp got);
            t_console_rsp e;
            if (want_words.size() == 0) begin
                $error("result word with nothing outstanding: %p", got);
                errors++;
                return;
            end
            e = want_words.pop_front();
            if (got.cell_char !== e.cell_char) begin
                $error("cell_char: expected %0d, got %0d", e.cell_char, got.cell_char);
                errors++;
            end
            if (got.cursor_col !== e.cursor_col) begin
                $error("cursor_col: expected %0d, got %0d", e.cursor_col, got.cursor_col);
                errors++;
            end
            if (got.cursor_row !== e.cursor_row) begin
                $error("cursor_row: expected %0d, got %0d", e.cursor_row, got.cursor_row);
                errors++;
            end
            if (got.did_scroll !== e.did_scroll) begin
                $error("did_scroll: expected %0d, got %0d", e.did_scroll, got.did_scroll);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    ttcw_pkg::t_cfg_idx i_cfg_addr;
    ttcw_pkg::t_cfg     i_cfg_data;

    ttcw_req_if req_if ();
    ttcw_rsp_if rsp_if ();

    t_screen_sb sb;

    int          req_idle_pct;
    int          rsp_idle_pct;
    int          nl_pct;
    int          big_scrolls;
    int          hold_asks = 0;
    int          hold_done = 0;
    int unsigned cycle_count = 0;

    text_terminal_char_writer_unit #(
        .MAX_COLS (GRID_COLS),
        .MAX_ROWS (GRID_ROWS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // receiver: random backpressure plus one long hold on request
    initial begin
        int   hold_left;
        logic take;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_asks != hold_done) begin
                hold_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else begin
                take = ($urandom_range(0, 99) >= rsp_idle_pct);
            end
            rsp_if.ready <= take;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            sb.check_word('{rsp_if.cell_char, rsp_if.cursor_col, rsp_if.cursor_row,
                            rsp_if.did_scroll});
        end
    end

    function automatic t_console_req put_word(ttcw_pkg::t_char ch);
        t_console_req w;
        w = '0;
        w.mode = ttcw_pkg::MODE_PUT;
        w.char_code = ch;
        return w;
    endfunction

    function automatic t_console_req read_word(int row, int col);
        t_console_req w;
        w = '0;
        w.mode = ttcw_pkg::MODE_READ;
        w.read_row = ttcw_pkg::ROW_W'(row);
        w.read_col = ttcw_pkg::COL_W'(col);
        return w;
    endfunction

    function automatic t_console_req make_word();
        t_console_req w;
        int           pick;
        int           ncols;
        int           nrows;
        logic         ordinary;
        logic         scrolls;
        ncols = sb.cols();
        nrows = sb.rows();
        w.mode = ttcw_pkg::MODE_PUT;
        w.char_code = ttcw_pkg::CHAR_W'($urandom_range(0, 255));
        w.read_row = ttcw_pkg::ROW_W'($urandom_range(0, 127));
        w.read_col = ttcw_pkg::COL_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            w.mode = ttcw_pkg::MODE_READ;
            if ($urandom_range(0, 3) != 0) begin
                w.read_row = ttcw_pkg::ROW_W'($urandom_range(0, nrows - 1));
                w.read_col = ttcw_pkg::COL_W'($urandom_range(0, ncols - 1));
            end
        end else if (pick < 20 + nl_pct) begin
            w.char_code = ttcw_pkg::CH_NEWLINE;
        end else if (pick < 20 + nl_pct + nl_pct / 2) begin
            w.char_code = ttcw_pkg::CH_RETURN;
        end else if (pick < 26 + nl_pct + nl_pct / 2) begin
            w.char_code = ttcw_pkg::CH_BACKSPACE;
        end
        if (w.mode == ttcw_pkg::MODE_PUT) begin
            ordinary = w.char_code != ttcw_pkg::CH_NEWLINE &&
                       w.char_code != ttcw_pkg::CH_RETURN &&
                       w.char_code != ttcw_pkg::CH_BACKSPACE;
            scrolls = (sb.cur_row + 1 >= nrows) &&
                      (w.char_code == ttcw_pkg::CH_NEWLINE || (ordinary && sb.cur_col >= ncols));
            // keep long copies of a large screen rare
            if (scrolls && ncols * nrows > SMALL_AREA) begin
                if (big_scrolls < 2) begin
                    big_scrolls++;
                end else begin
                    w.char_code = ttcw_pkg::CH_RETURN;
                end
            end
        end
        return w;
    endfunction

    task automatic send_word(t_console_req w);
        while ($urandom_range(0, 99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.mode      <= w.mode;
        req_if.char_code <= w.char_code;
        req_if.read_row  <= w.read_row;
        req_if.read_col  <= w.read_col;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_word(w);
    endtask

    task automatic write_window(ttcw_pkg::t_cfg w, ttcw_pkg::t_cfg h);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= ttcw_pkg::REG_WIN_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        sb.set_reg(ttcw_pkg::REG_WIN_WIDTH, w);
        i_cfg_addr <= ttcw_pkg::REG_WIN_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        sb.set_reg(ttcw_pkg::REG_WIN_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    // drain results, then let any scroll copy finish
    task automatic wait_settled();
        req_if.valid <= 1'b0;
        while (sb.want_words.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        ttcw_pkg::t_cfg pw;
        ttcw_pkg::t_cfg ph_h;
        sb = new();
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_addr       <= ttcw_pkg::REG_WIN_WIDTH;
        i_cfg_data       <= '0;
        req_if.valid     <= 1'b0;
        req_if.mode      <= ttcw_pkg::MODE_PUT;
        req_if.char_code <= '0;
        req_if.read_row  <= '0;
        req_if.read_col  <= '0;
        req_idle_pct = 23;
        rsp_idle_pct = 71;
        nl_pct       = 10;
        big_scrolls  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_window(12'd0, 12'd0);
        send_word(read_word(0, 0));
        send_word(put_word(8'h00));
        send_word(put_word(8'hFF));
        send_word(put_word("A"));
        repeat (4) send_word(put_word(ttcw_pkg::CH_BACKSPACE));
        send_word(put_word("Z"));
        send_word(put_word(ttcw_pkg::CH_RETURN));
        send_word(read_word(0, 0));
        send_word(read_word(GRID_ROWS, 0));
        send_word(read_word(0, GRID_COLS));
        send_word(read_word(127, 255));
        send_word(read_word(GRID_ROWS - 1, GRID_COLS - 1));
        repeat (10) send_word(put_word(ttcw_pkg::CH_NEWLINE));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_settled();
            case (ph)
                0: begin pw = 12'd15;   ph_h = 12'd35;   nl_pct = 10; end
                1: begin pw = 12'd1616; ph_h = 12'd4095; nl_pct = 14; end
                2: begin pw = 12'd376;  ph_h = 12'd132;  nl_pct = 10; end
                3: begin pw = 12'd4095; ph_h = 12'd0;    nl_pct = 1;  end
                4: begin pw = 12'd0;    ph_h = 12'd4095; nl_pct = 14; end
                5: begin pw = 12'd640;  ph_h = 12'd480;  nl_pct = 10; end
                6: begin pw = 12'd1624; ph_h = 12'd836;  nl_pct = 1;  end
                default: begin pw = 12'd100; ph_h = 12'd200; nl_pct = 10; end
            endcase
            if (ph == 3) begin
                req_idle_pct = 71;
                rsp_idle_pct = 23;
            end
            if (ph == 6) begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            big_scrolls = 0;
            write_window(pw, ph_h);
            if (ph == 6) hold_asks++;
            for (int k = 0; k < PHASE_WORDS; k++) send_word(make_word());
        end
        wait_settled();

        $display("Covered %0d puts and %0d cell reads over %0d window sizes, %0d scrolls.",
                 sb.puts, sb.reads, PHASES + 1, sb.scrolls);
        $display("Mismatches: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
